### hw/rtl/wma_pkg.sv
`timescale 1ns / 1ps
package wma_pkg;

    localparam int SAMPLE_W = 17;   // command payload and result width
    localparam int STORE_W  = 16;   // bits kept per stored sample
    localparam int CFG_SZ_W = 9;    // window_size register width
    localparam int CFG_TY_W = 2;    // sample_type register width
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // sample formats
    localparam logic [1:0] FMT_S8  = 2'd0;
    localparam logic [1:0] FMT_U8  = 2'd1;
    localparam logic [1:0] FMT_S16 = 2'd2;
    localparam logic [1:0] FMT_U16 = 2'd3;

    // register index (paddr[2])
    localparam logic REG_SAMPLE_TYPE = 1'b0;
    localparam logic REG_WINDOW_SIZE = 1'b1;

    localparam logic [CFG_TY_W-1:0] RST_SAMPLE_TYPE = FMT_S8;
    localparam logic [CFG_SZ_W-1:0] RST_WINDOW_SIZE = 9'd16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    function automatic t_sample f_decode(input logic [STORE_W-1:0] bits,
                                         input logic [1:0] kind);
        t_sample res;
        case (kind)
            FMT_S8:  res = {{9{bits[7]}}, bits[7:0]};
            FMT_U8:  res = {9'b0, bits[7:0]};
            FMT_S16: res = {bits[15], bits};
            FMT_U16: res = {1'b0, bits};
            default: res = {1'b0, bits};
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/wma_div.sv
`timescale 1ns / 1ps
module wma_div #(
    parameter int DEND_W = 26,
    parameter int DSOR_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DEND_W-1:0] i_dividend,
    input  logic [DSOR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DEND_W-1:0] o_quotient
);

    localparam int CW = $clog2(DEND_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DSOR_W-1:0] r_rem;
    logic [DSOR_W-1:0] r_dsor;
    logic [DEND_W-1:0] r_quo;

    logic [DSOR_W:0]   w_shift;
    logic [DSOR_W:0]   w_trial;
    logic              w_ge;

    // restoring division, one quotient bit per cycle; dividend shifts out
    // of the top of r_quo while quotient bits shift in at the bottom
    assign w_shift = {r_rem, r_quo[DEND_W-1]};
    assign w_trial = w_shift - {1'b0, r_dsor};
    assign w_ge    = !w_trial[DSOR_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dsor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DSOR_W-1:0] : w_shift[DSOR_W-1:0];
            r_quo <= {r_quo[DEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hw/rtl/windowed_moving_average.sv
`timescale 1ns / 1ps
// Moving average over the last window_size samples (up to MAX_WINDOW). Each
// input beat pushes a sample, fills the window with one value, or clears it,
// and yields exactly one output beat with the rounded (ties away from zero)
// mean of the valid samples, or 0 when the window is empty. One item at a
// time: each item passes through the update, prepare, divide and output
// states, and the bit-serial restoring divider produces one quotient bit
// per cycle over the SUM_W-bit dividend. The next input beat is taken only
// once the block is back in idle after loading the result; output stalls
// delay that only while an earlier result still waits.
// A finished result waits in the output register while the next item is
// accepted. sample_type and window_size writes take effect at the next fill
// or clear command. Fill needs no sweep of the sample memory: untouched
// entries read back as the fill value until the pointer wraps.
module windowed_moving_average
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_command,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_average,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam logic [CFG_SZ_W-1:0] MAX_SZ = CFG_SZ_W'(MAX_WINDOW);
    localparam logic [CNT_W-1:0] RST_ACT_SIZE =
        (RST_WINDOW_SIZE > MAX_SZ) ? CNT_W'(MAX_WINDOW) : CNT_W'(RST_WINDOW_SIZE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // configuration
    logic [CFG_TY_W-1:0] r_sample_type;
    logic [CFG_SZ_W-1:0] r_window_size;
    logic                w_cfg_wr;

    // control
    logic [2:0]          r_state, n_state;
    logic [CFG_TY_W-1:0] r_act_type, n_act_type;
    logic [CNT_W-1:0]    r_act_size, n_act_size;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic                r_full, n_full;
    logic                r_pristine, n_pristine;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                r_neg, n_neg;
    logic                r_zero, n_zero;
    logic                r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_average, n_average;

    // payload
    logic [1:0]          r_cmd;
    logic [SAMPLE_W-1:0] r_raw;
    t_sample             r_fill_val;
    logic [STORE_W-1:0]  r_mem [MAX_WINDOW];
    logic [STORE_W-1:0]  r_rd_data;

    logic                w_accept;
    logic                w_reload;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_cfg_size;
    logic [CFG_TY_W-1:0] w_type;
    t_sample             w_v;
    t_sample             w_old;
    logic signed [SUM_W-1:0] w_sub;
    logic signed [SUM_W:0]   w_prod;
    logic                w_ptr_last;
    logic [CNT_W-1:0]    w_count;
    logic [SUM_W-1:0]    w_mag;
    logic [SUM_W-1:0]    w_dividend;
    logic                w_div_start;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quo;
    logic [SAMPLE_W-1:0] w_q;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_type <= RST_SAMPLE_TYPE;
            r_window_size <= RST_WINDOW_SIZE;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_SAMPLE_TYPE: r_sample_type <= pwdata[CFG_TY_W-1:0];
                REG_WINDOW_SIZE: r_window_size <= pwdata[CFG_SZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SAMPLE_TYPE: prdata = {{(APB_DW-CFG_TY_W){1'b0}}, r_sample_type};
            REG_WINDOW_SIZE: prdata = {{(APB_DW-CFG_SZ_W){1'b0}}, r_window_size};
            default:         prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_window_size == '0)
            w_cfg_size = CNT_W'(1);
        else if (r_window_size > MAX_SZ)
            w_cfg_size = CNT_W'(MAX_WINDOW);
        else
            w_cfg_size = r_window_size[CNT_W-1:0];
    end

    // fill and clear latch the new format before decoding
    assign w_reload   = (r_cmd == CMD_FILL) || (r_cmd == CMD_CLEAR);
    assign w_type     = w_reload ? r_sample_type : r_act_type;
    assign w_v        = f_decode(r_raw[STORE_W-1:0], w_type);
    assign w_old      = r_pristine ? r_fill_val : f_decode(r_rd_data, r_act_type);
    assign w_sub      = r_full ? SUM_W'(w_old) : '0;
    assign w_prod     = w_v * $signed({1'b0, w_cfg_size});
    assign w_ptr_last = (CNT_W'(r_ptr) == r_act_size - 1'b1);

    assign w_count    = r_full ? r_act_size : CNT_W'(r_ptr);
    assign w_mag      = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_dividend = w_mag + SUM_W'(w_count >> 1);
    assign w_div_start = (r_state == S_PREP);
    assign w_q        = w_quo[SAMPLE_W-1:0];

    // sample memory: the read port follows the write pointer every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD && r_cmd == CMD_PUSH)
            r_mem[r_ptr] <= w_v[STORE_W-1:0];
        r_rd_data <= r_mem[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
            r_raw <= i_sample_value;
        end
        if (r_state == S_UPD && r_cmd == CMD_FILL)
            r_fill_val <= w_v;
    end

    always_comb begin
        n_state     = r_state;
        n_act_type  = r_act_type;
        n_act_size  = r_act_size;
        n_ptr       = r_ptr;
        n_full      = r_full;
        n_pristine  = r_pristine;
        n_sum       = r_sum;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        n_average   = r_average;
        case (r_state)
            S_IDLE: begin
                if (w_accept)
                    n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_PREP;
                case (r_cmd)
                    CMD_PUSH: begin
                        n_sum = r_sum - w_sub + SUM_W'(w_v);
                        if (w_ptr_last) begin
                            n_ptr      = '0;
                            n_full     = 1'b1;
                            n_pristine = 1'b0;
                        end else begin
                            n_ptr = r_ptr + 1'b1;
                        end
                    end
                    CMD_FILL: begin
                        n_act_type = r_sample_type;
                        n_act_size = w_cfg_size;
                        n_sum      = w_prod[SUM_W-1:0];
                        n_ptr      = '0;
                        n_full     = 1'b1;
                        n_pristine = 1'b1;
                    end
                    CMD_CLEAR: begin
                        n_act_type = r_sample_type;
                        n_act_size = w_cfg_size;
                        n_sum      = '0;
                        n_ptr      = '0;
                        n_full     = 1'b0;
                        n_pristine = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_PREP: begin
                n_neg   = r_sum[SUM_W-1];
                n_zero  = (w_count == '0);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done)
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_average   = r_zero ? '0 : (r_neg ? -$signed(w_q) : $signed(w_q));
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_act_type  <= RST_SAMPLE_TYPE;
            r_act_size  <= RST_ACT_SIZE;
            r_ptr       <= '0;
            r_full      <= 1'b0;
            r_pristine  <= 1'b0;
            r_sum       <= '0;
            r_neg       <= 1'b0;
            r_zero      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_act_type  <= n_act_type;
            r_act_size  <= n_act_size;
            r_ptr       <= n_ptr;
            r_full      <= n_full;
            r_pristine  <= n_pristine;
            r_sum       <= n_sum;
            r_neg       <= n_neg;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_average <= n_average;
    end

    assign o_out_valid = r_out_valid;
    assign o_average   = r_average;

    wma_div #(
        .DEND_W (SUM_W),
        .DSOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ---------------- assertions ----------------
    a_ptr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_ptr) < r_act_size)
        else $error("write pointer beyond active window");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_size != '0 && r_act_size <= CNT_W'(MAX_WINDOW))
        else $error("active window size out of range");

    a_pristine_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pristine |-> r_full)
        else $error("fill-shadow entries outside a full window");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

endmodule
